// File: rtl/line_editor_with_echo_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line editor core
// Immediate-cycle and next-cycle implication checks on the core clock.
// ----------------------------------------------------------------------------
`ifndef LINE_EDITOR_WITH_ECHO_CORE_ASSERT_SVH
`define LINE_EDITOR_WITH_ECHO_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LEWE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LEWE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lewe_pkg.sv
// ----------------------------------------------------------------------------
// lewe_pkg
// Shared types, character codes and the result expansion table of the
// line editor core.
// ----------------------------------------------------------------------------
package lewe_pkg;

    // Result kinds on the output channel.
    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_STORE = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    // Command classes handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_LINE_END = 3'd0,
        OP_CHAR     = 3'd1,
        OP_CHAR_FIN = 3'd2,
        OP_BS       = 3'd3,
        OP_DEL      = 3'd4
    } op_t;

    // Character codes.
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam int unsigned CNT_W      = 9;
    localparam int unsigned STEP_W     = 3;
    localparam int unsigned CMDQ_DEPTH = 2;
    localparam int unsigned CMDQ_PTR_W = 1;
    localparam int unsigned CMDQ_CNT_W = 2;
    localparam logic [STEP_W-1:0] STEP_MAX = 3'd4;

    // One classified input byte.
    typedef struct packed {
        op_t              op;
        logic [7:0]       data;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] len;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data;
        logic [CNT_W-1:0] position;
        logic             last;
    } res_t;

    // Result number 'step' of the sequence that a command expands into.
    function automatic res_t lewe_result(input cmd_t c, input logic [STEP_W-1:0] step);
        res_t r;
        r.kind     = KIND_ECHO;
        r.data     = 8'h00;
        r.position = '0;
        r.last     = 1'b0;
        unique case (c.op)
            OP_LINE_END:
            begin
                unique case (step)
                    3'd0:    r.data = CH_CR;
                    3'd1:    r.data = CH_LF;
                    default:
                    begin
                        r.kind     = KIND_DONE;
                        r.position = c.len;
                        r.last     = 1'b1;
                    end
                endcase
            end
            OP_CHAR:
            begin
                unique case (step)
                    3'd0:
                    begin
                        r.kind     = KIND_STORE;
                        r.data     = c.data;
                        r.position = c.pos;
                    end
                    default:
                    begin
                        r.data = c.data;
                        r.last = 1'b1;
                    end
                endcase
            end
            OP_CHAR_FIN:
            begin
                unique case (step)
                    3'd0:
                    begin
                        r.kind     = KIND_STORE;
                        r.data     = c.data;
                        r.position = c.pos;
                    end
                    3'd1:    r.data = c.data;
                    3'd2:    r.data = CH_CR;
                    3'd3:    r.data = CH_LF;
                    default:
                    begin
                        r.kind     = KIND_DONE;
                        r.position = c.len;
                        r.last     = 1'b1;
                    end
                endcase
            end
            OP_BS:
            begin
                unique case (step)
                    3'd0:
                    begin
                        r.kind     = KIND_STORE;
                        r.data     = c.data;
                        r.position = c.pos;
                    end
                    3'd1:    r.data = c.data;
                    3'd2:    r.data = CH_SP;
                    default:
                    begin
                        r.data = CH_BS;
                        r.last = 1'b1;
                    end
                endcase
            end
            OP_DEL:
            begin
                unique case (step)
                    3'd0:
                    begin
                        r.kind     = KIND_STORE;
                        r.data     = c.data;
                        r.position = c.pos;
                    end
                    3'd1:    r.data = c.data;
                    3'd2:    r.data = CH_BS;
                    3'd3:    r.data = CH_SP;
                    default:
                    begin
                        r.data = CH_BS;
                        r.last = 1'b1;
                    end
                endcase
            end
            default: r.last = 1'b1;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/line_editor_with_echo_core.sv
// ----------------------------------------------------------------------------
// line_editor_with_echo_core
// Terminal line editor: stores received bytes, echoes them with erase
// handling and reports completed lines.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on rx_byte with push/full; a transaction is
// taken when push is high and full is low. Results leave as a queue: while
// empty is low, kind, byte_value, position and last show the oldest result,
// and pop takes it. Each byte yields, in order, a store into the line buffer
// (not for CR), echo bytes and possibly a line-complete transaction (always
// for CR); last marks the final result of a byte. ESC yields nothing. The line
// limit is written over the APB port (byte address 0); write it only while the
// core is idle; the block does not enforce it. A byte's results pass through
// the command queue and the output register. The back end emits one result
// per cycle unless pop stalls, and a byte expands into 2 to 5 results (3 for
// CR); the two-entry command queue lets the front end take the next byte while
// the back end works. A stall on pop holds the output register; the queue
// then fills and full rises. Reset clears the character count, empties the
// queue and the output register, and sets the line limit to 256.
// ----------------------------------------------------------------------------
module line_editor_with_echo_core #(
    parameter int unsigned MAX_LINE = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    // Result channel
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  byte_value,
    output logic [8:0]  position,
    output logic        last
);
    import lewe_pkg::*;

    `include "line_editor_with_echo_core_assert.svh"

    logic [8:0] line_limit_reg;
    logic       cfg_wr;
    logic       accept;
    logic       cmd_wr;
    cmd_t       cmd_in;
    cmd_t       cmd_head;
    logic       cmd_valid;
    logic       cmd_rd;
    logic       q_full;
    logic       out_valid;
    res_t       res;
    logic [8:0] count;
    logic [2:0] step;

    // Configuration register access.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {23'd0, line_limit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= 9'd256;
        end
        else if (cfg_wr)
        begin
            line_limit_reg <= pwdata[8:0];
        end
    end

    // Input handshake.
    assign full   = q_full;
    assign accept = push && !q_full;

    lewe_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .line_limit (line_limit_reg),
        .cmd_wr     (cmd_wr),
        .cmd        (cmd_in),
        .count      (count)
    );

    lewe_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_wr),
        .din   (cmd_in),
        .rd    (cmd_rd),
        .dout  (cmd_head),
        .full  (q_full),
        .valid (cmd_valid)
    );

    lewe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_valid (cmd_valid),
        .cmd_rd    (cmd_rd),
        .pop       (pop),
        .out_valid (out_valid),
        .res       (res),
        .step      (step)
    );

    // Result channel.
    assign empty      = !out_valid;
    assign kind       = res.kind;
    assign byte_value = res.data;
    assign position   = res.position;
    assign last       = res.last;

    // Checks on the internal handoff.
    `LEWE_ASSERT_SAME(a_no_write_when_full, push && full, !cmd_wr, "queue written while full")
    `LEWE_ASSERT_NEXT(a_count_clears_at_line_end, cmd_wr && (cmd_in.op == OP_LINE_END || cmd_in.op == OP_CHAR_FIN), count == 9'd0, "count not cleared at line end")
    `LEWE_ASSERT_SAME(a_done_is_last, !empty && kind == KIND_DONE, last && byte_value == 8'd0, "line complete not final")
    `LEWE_ASSERT_SAME(a_step_in_range, 1'b1, step <= STEP_MAX, "step counter out of range")

endmodule

// File: rtl/lewe_front.sv
// ----------------------------------------------------------------------------
// lewe_front
// Classifies each received byte, keeps the character count of the current
// line and writes one command per non-ESC byte into the command queue.
// ----------------------------------------------------------------------------
module lewe_front #(
    parameter int unsigned MAX_LINE = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            rx_byte,
    input  logic [8:0]            line_limit,
    output logic                  cmd_wr,
    output lewe_pkg::cmd_t        cmd,
    output logic [8:0]            count
);
    import lewe_pkg::*;

    localparam logic [16:0] MaxLine = 17'(MAX_LINE);

    logic [CNT_W-1:0] char_count_reg;
    logic [CNT_W-1:0] char_count_next;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] cnt_inc;
    logic             is_esc;
    logic             is_cr;
    logic             is_bs;
    logic             is_del;
    logic             reach;

    // Effective limit, clamped to the largest line the buffer holds.
    always_comb
    begin
        if ({8'd0, line_limit} > MaxLine)
        begin
            lim = MaxLine[CNT_W-1:0];
        end
        else
        begin
            lim = line_limit;
        end
    end

    // Byte classification and the count after a stored character.
    assign is_esc  = (rx_byte == CH_ESC);
    assign is_cr   = (rx_byte == CH_CR);
    assign is_bs   = (rx_byte == CH_BS);
    assign is_del  = (rx_byte == CH_DEL);
    assign cnt_inc = char_count_reg + 9'd1;
    assign reach   = (cnt_inc >= lim);

    // Command built for the back end.
    always_comb
    begin
        cmd.data = rx_byte;
        cmd.pos  = char_count_reg;
        cmd.len  = cnt_inc;
        priority if (is_cr)
        begin
            cmd.op  = OP_LINE_END;
            cmd.len = char_count_reg;
        end
        else if (is_del)
        begin
            cmd.op = OP_DEL;
        end
        else if (is_bs)
        begin
            cmd.op = OP_BS;
        end
        else if (reach)
        begin
            cmd.op = OP_CHAR_FIN;
        end
        else
        begin
            cmd.op = OP_CHAR;
        end
    end

    assign cmd_wr = accept && !is_esc;

    // Count update: cleared at line end, clamped at zero on erase.
    always_comb
    begin
        char_count_next = char_count_reg;
        if (cmd_wr)
        begin
            priority if (is_cr)
            begin
                char_count_next = '0;
            end
            else if (is_bs || is_del)
            begin
                char_count_next = (char_count_reg == '0) ? '0 : char_count_reg - 9'd1;
            end
            else if (reach)
            begin
                char_count_next = '0;
            end
            else
            begin
                char_count_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg <= '0;
        end
        else
        begin
            char_count_reg <= char_count_next;
        end
    end

    assign count = char_count_reg;

endmodule

// File: rtl/lewe_cmdq.sv
// ----------------------------------------------------------------------------
// lewe_cmdq
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lewe_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  lewe_pkg::cmd_t din,
    input  logic           rd,
    output lewe_pkg::cmd_t dout,
    output logic           full,
    output logic           valid
);
    import lewe_pkg::*;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] fill_reg;
    logic [CMDQ_CNT_W-1:0] fill_next;

    assign full  = (fill_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign valid = (fill_reg != '0);
    assign dout  = entry_reg[rd_ptr_reg];

    // Fill level follows writes and reads.
    always_comb
    begin
        fill_next = fill_reg;
        if (wr && !rd)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: rtl/lewe_back.sv
// ----------------------------------------------------------------------------
// lewe_back
// Expands the queue's head command into its result transactions, one
// per cycle unless pop stalls, through an output register.
// ----------------------------------------------------------------------------
module lewe_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lewe_pkg::cmd_t       cmd,
    input  logic                 cmd_valid,
    output logic                 cmd_rd,
    input  logic                 pop,
    output logic                 out_valid,
    output lewe_pkg::res_t       res,
    output logic [2:0]           step
);
    import lewe_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    res_t              res_reg;
    res_t              res_now;
    logic              load;
    logic              pop_ok;

    assign res_now = lewe_result(cmd, step_reg);
    assign pop_ok  = pop && out_valid_reg;
    assign load    = cmd_valid && (!out_valid_reg || pop_ok);
    assign cmd_rd  = load && res_now.last;

    // Step counter within the current command.
    always_comb
    begin
        step_next = step_reg;
        if (load)
        begin
            step_next = res_now.last ? '0 : step_reg + 3'd1;
        end
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop_ok)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign step      = step_reg;

endmodule

// File: tb/sv/tb_line_editor_with_echo_core.sv
// ----------------------------------------------------------------------------
// tb_line_editor_with_echo_core
// Self-checking bench for the line editor core. Received bytes are pushed in
// and every result transaction that comes out is compared, in order, with
// the results that a behavioral model of the editor predicts. It covers erase
// handling, carriage return, escape dropping and the forced end of a line at
// the programmed limit. The limit is reprogrammed over APB between phases,
// and each phase uses one of four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_line_editor_with_echo_core;

    timeunit 1ns;
    timeprecision 1ps;

    import lewe_pkg::*;

    localparam int unsigned    LINE_CAP       = 256;
    localparam logic [2:0]     REG_LINE_LIMIT = 3'd0;
    localparam int unsigned    CYCLE_LIMIT    = 400000;
    localparam int unsigned    SETTLE_CYCLES  = 16;
    localparam int unsigned    NUM_PHASES     = 12;

    typedef logic [7:0] byte_q_t[$];

    // One result transaction as the editor should emit it.
    typedef struct {
        kind_t      kind;
        logic [7:0] value;
        logic [8:0] pos;
        logic       last;
    } echo_result_t;

    // Behavioral model of the editor plus the queue of results still owed.
    class echo_scoreboard;
        logic [8:0]   line_limit;
        logic [8:0]   char_count;
        echo_result_t owed[$];
        int unsigned  failures;

        function new();
            line_limit = 9'd256;
            char_count = '0;
            failures   = 0;
        endfunction

        function void set_limit(logic [8:0] v);
            line_limit = v;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_failure(string msg);
            if (failures < 10)
                $display("%0t: %s", $realtime, msg);
            failures++;
        endfunction

        // Works out the results of one accepted byte and queues them.
        function void note_byte(logic [7:0] b);
            echo_result_t step_q[$];
            logic [8:0]   lim;
            lim = (line_limit > LINE_CAP) ? 9'(LINE_CAP) : line_limit;
            if (b == CH_ESC)
                return;
            if (b == CH_CR)
            begin
                add_line_end(step_q, char_count);
            end
            else
            begin
                step_q.push_back('{KIND_STORE, b, char_count, 1'b0});
                step_q.push_back('{KIND_ECHO, b, 9'd0, 1'b0});
                if (b == CH_DEL)
                    step_q.push_back('{KIND_ECHO, CH_BS, 9'd0, 1'b0});
                if (b == CH_BS || b == CH_DEL)
                begin
                    step_q.push_back('{KIND_ECHO, CH_SP, 9'd0, 1'b0});
                    step_q.push_back('{KIND_ECHO, CH_BS, 9'd0, 1'b0});
                    // Erasing on an empty line leaves the count at zero.
                    char_count = (char_count != 0) ? char_count - 9'd1 : 9'd0;
                end
                else
                begin
                    char_count = char_count + 9'd1;
                    if (char_count >= lim)
                        add_line_end(step_q, char_count);
                end
            end
            step_q[step_q.size()-1].last = 1'b1;
            foreach (step_q[i])
                owed.push_back(step_q[i]);
        endfunction

        // CR LF echo followed by the line-complete transaction.
        function void add_line_end(ref echo_result_t step_q[$], input logic [8:0] len);
            step_q.push_back('{KIND_ECHO, CH_CR, 9'd0, 1'b0});
            step_q.push_back('{KIND_ECHO, CH_LF, 9'd0, 1'b0});
            step_q.push_back('{KIND_DONE, 8'h00, len, 1'b0});
            char_count = '0;
        endfunction

        // Compares one accepted result with the oldest owed result.
        function void check_result(logic [1:0] k, logic [7:0] v, logic [8:0] p, logic l);
            echo_result_t e;
            if (owed.size() == 0)
            begin
                note_failure($sformatf("unexpected result kind=%0d byte=%02h pos=%0d last=%0b",
                                       k, v, p, l));
                return;
            end
            e = owed.pop_front();
            if (k !== e.kind || v !== e.value || p !== e.pos || l !== e.last)
                note_failure($sformatf({"result mismatch: expected kind=%0d byte=%02h ",
                                        "pos=%0d last=%0b, got kind=%0d byte=%02h ",
                                        "pos=%0d last=%0b"},
                                       e.kind, e.value, e.pos, e.last, k, v, p, l));
        endfunction
    endclass

    // Clock, reset and block inputs, all known from time zero.
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic        push    = 1'b0;
    logic [7:0]  rx_byte = '0;
    logic        pop     = 1'b0;

    logic [31:0] prdata;
    logic        pready;
    logic        full;
    logic        empty;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [8:0]  position;
    logic        last;

    echo_scoreboard sb;
    int unsigned    cycle_count    = 0;
    int unsigned    send_idle_pct  = 0;
    int unsigned    pop_stall_pct  = 0;

    line_editor_with_echo_core #(
        .MAX_LINE (LINE_CAP)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .byte_value (byte_value),
        .position   (position),
        .last       (last)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Receiver side: stall pop at random at the rate of the current phase.
    always @(posedge clk)
        pop <= ($urandom_range(99) >= pop_stall_pct);

    // Monitor both channels at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_byte(rx_byte);
            if (pop && !empty)
                sb.check_result(kind, byte_value, position, last);
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Sends one byte, with random gaps before it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic feed(input byte_q_t bytes);
        foreach (bytes[i])
            send_byte(bytes[i]);
        push <= 1'b0;
    endtask

    // Waits until every owed result has come out and the core is quiet.
    task automatic drain();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of the line limit; the model follows at the same edge.
    // The bus is left idle before the task returns.
    task automatic write_limit(input logic [8:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_LINE_LIMIT;
        pwdata  <= {23'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_limit(v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // APB read of the line limit, checked against the programmed value.
    task automatic check_limit(input logic [8:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_LINE_LIMIT;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[8:0] !== v)
            sb.note_failure($sformatf("line limit read: expected %0d, got %0d",
                                      v, prdata[8:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_idle_mode(input int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 83; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 83; end
            default: begin send_idle_pct = 25; pop_stall_pct = 25; end
        endcase
    endtask

    // Printable-or-binary byte that is none of the control codes.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_CR || b == CH_ESC || b == CH_BS || b == CH_DEL);
        return b;
    endfunction

    // Mixed byte with weighted control codes.
    function automatic logic [7:0] mixed_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return CH_CR;
        else if (r < 20)
            return CH_BS;
        else if (r < 30)
            return CH_DEL;
        else if (r < 35)
            return CH_ESC;
        return 8'($urandom_range(255));
    endfunction

    initial
    begin
        logic [8:0]  phase_limit [NUM_PHASES];
        int unsigned phase_items;
        sb = new();
        phase_limit = '{9'd511, 9'd300, 9'd257, 9'd384, 9'd0, 9'd1, 9'd2, 9'd5,
                        9'd9, 9'd256, 9'd0, 9'd0};
        phase_limit[10] = 9'($urandom_range(1, 16));
        phase_limit[11] = 9'($urandom_range(0, 511));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idle_mode(0);
        check_limit(9'd256);

        // Erase on an empty line, extreme bytes, erase back to zero, CR on
        // a filled and on an empty line, and escape dropping.
        feed('{CH_ESC, CH_BS, CH_DEL, 8'h00, 8'hFF, 8'h41, CH_BS, CH_DEL, CH_DEL,
               CH_DEL, 8'h68, 8'h69, CH_CR, CH_CR, CH_LF, 8'h1C, CH_CR});
        drain();

        // A limit of one and a limit of zero both end the line at once.
        write_limit(9'd1);
        feed('{8'h71});
        drain();
        write_limit(9'd0);
        feed('{CH_CR, 8'h7A});
        drain();

        // Limit lowered below the count: an erase does not end the line,
        // the next stored byte does.
        write_limit(9'd256);
        feed('{8'h61, 8'h62, 8'h63});
        drain();
        write_limit(9'd1);
        check_limit(9'd1);
        feed('{CH_BS, 8'h78});
        drain();

        // Random phases. The first four build one long line of plain bytes
        // against limits above the buffer size, so it ends at the cap.
        for (int unsigned p = 0; p < NUM_PHASES; p++)
        begin
            set_idle_mode(p % 4);
            write_limit(phase_limit[p]);
            check_limit(phase_limit[p]);
            phase_items = (p < 4) ? 64 : 7;
            for (int unsigned i = 0; i < phase_items; i++)
                send_byte((p < 4) ? plain_byte() : mixed_byte());
            push <= 1'b0;
            drain();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
